>>> hdl/midi_note_track_encoder_core_defines.svh
// Assertion helpers shared by the encoder modules.
// They expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef MIDI_NOTE_TRACK_ENCODER_CORE_DEFINES_SVH
`define MIDI_NOTE_TRACK_ENCODER_CORE_DEFINES_SVH

`define MNTE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`define MNTE_ASSERT_NEVER(label, cond, msg) \
	`MNTE_ASSERT(label, !(cond), msg)

`endif

>>> hdl/mnte_pkg.sv
package mnte_pkg;

	localparam int TICK_BITS_DEF = 28;
	localparam int VLQ_BITS      = 28;
	localparam int DUR_BITS      = 17;
	localparam int TPQ_BITS      = 15;
	localparam int MAX_BYTES     = 13;
	localparam int MIN_BURST     = 4;
	localparam int CNT_BITS      = 4;
	localparam int VEC_BITS      = MAX_BYTES * 8;

	localparam logic [TPQ_BITS-1:0] TPQ_RESET = 15'd480;

	localparam logic [7:0] VELOCITY   = 8'h64;
	localparam logic [7:0] META_EVENT = 8'hFF;
	localparam logic [7:0] META_EOT   = 8'h2F;
	localparam logic [3:0] NOTE_ON    = 4'h9;
	localparam logic [3:0] NOTE_OFF   = 4'h8;

	localparam logic [3:0] MAJOR_STEPS [7] = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11};
	localparam logic [3:0] MINOR_STEPS [7] = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10};

	typedef enum logic [1:0] {
		CFG_KEY_ROOT  = 2'd0,
		CFG_KEY_MINOR = 2'd1,
		CFG_TPQ       = 2'd2,
		CFG_VOICE     = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		DUR_WHOLE          = 4'd0,
		DUR_DOTTED_HALF    = 4'd1,
		DUR_HALF           = 4'd2,
		DUR_DOTTED_QUARTER = 4'd3,
		DUR_QUARTER        = 4'd4,
		DUR_DOTTED_EIGHTH  = 4'd5,
		DUR_EIGHTH         = 4'd6,
		DUR_SIXTEENTH      = 4'd7
	} dur_code_t;

	typedef struct packed {
		logic [VEC_BITS-1:0] bytes;
		logic [CNT_BITS-1:0] count;
	} burst_t;

	typedef struct packed {
		logic [31:0] bytes;
		logic [2:0]  count;
	} vlq_t;

	// Bytes come out in emission order, first byte in the low bits.
	function automatic vlq_t vlq_encode(input logic [VLQ_BITS-1:0] v);
		logic [6:0] grp [4];
		logic [2:0] k;
		vlq_t r;
		for (int g = 0; g < 4; g++) begin
			grp[g] = v[7*g +: 7];
		end
		if (grp[3] != 7'd0) begin
			r.count = 3'd4;
		end else if (grp[2] != 7'd0) begin
			r.count = 3'd3;
		end else if (grp[1] != 7'd0) begin
			r.count = 3'd2;
		end else begin
			r.count = 3'd1;
		end
		r.bytes = '0;
		k = '0;
		for (int j = 0; j < 4; j++) begin
			if (3'(j) < r.count) begin
				k = r.count - 3'(j) - 3'd1;
				r.bytes[8*j +: 8] = {(3'(j) != r.count - 3'd1), grp[k[1:0]]};
			end
		end
		return r;
	endfunction

	function automatic logic [6:0] note_number(input logic [3:0] root, input logic minor,
		input logic [1:0] voice, input logic [4:0] degree);
		logic [4:0] idx;
		logic [2:0] oct;
		logic [4:0] rem;
		logic [3:0] root_e;
		logic [3:0] step;
		logic [6:0] base;
		root_e = (root < 4'd12) ? root : 4'd0;
		idx = (degree == 5'd0) ? 5'd0 : degree - 5'd1;
		if (idx >= 5'd28) begin
			oct = 3'd4;
		end else if (idx >= 5'd21) begin
			oct = 3'd3;
		end else if (idx >= 5'd14) begin
			oct = 3'd2;
		end else if (idx >= 5'd7) begin
			oct = 3'd1;
		end else begin
			oct = 3'd0;
		end
		rem = idx - 5'(7 * oct);
		step = minor ? MINOR_STEPS[rem[2:0]] : MAJOR_STEPS[rem[2:0]];
		base = 7'(12 * (3'd4 - {1'b0, voice}));
		return 7'({3'b000, root_e} + base + {3'b000, step} + 7'(12 * oct));
	endfunction

	function automatic logic [DUR_BITS-1:0] duration_ticks(input logic [3:0] code,
		input logic [TPQ_BITS-1:0] t);
		logic [DUR_BITS-1:0] t3;
		logic [DUR_BITS-1:0] r;
		t3 = {2'b00, t} + {1'b0, t, 1'b0};
		case (code)
			DUR_WHOLE:          r = {t, 2'b00};
			DUR_DOTTED_HALF:    r = t3;
			DUR_HALF:           r = {1'b0, t, 1'b0};
			DUR_DOTTED_QUARTER: r = {1'b0, t3[DUR_BITS-1:1]};
			DUR_QUARTER:        r = {2'b00, t};
			DUR_DOTTED_EIGHTH:  r = {2'b00, t3[DUR_BITS-1:2]};
			DUR_EIGHTH:         r = {3'b000, t[TPQ_BITS-1:1]};
			DUR_SIXTEENTH:      r = {4'b0000, t[TPQ_BITS-1:2]};
			default:            r = {2'b00, t};
		endcase
		return r;
	endfunction

endpackage

>>> hdl/midi_note_track_encoder_core.sv
// Encodes the note events of one track into standard MIDI file track bytes.
// Configuration: write key root, key mode, ticks per quarter and voice through
// cfg_we, cfg_index and cfg_data while the block is idle; writes take effect at once.
// Input channel: one beat per note event, rest or end-of-track item, taken on
// in_valid and in_ready. Output channel: one track byte per beat on out_valid and
// out_ready, with last marking the final byte of an item.
// A note event gives 8 to 13 bytes: delta time VLQ, note-on, duration VLQ and
// note-off. An end item gives four bytes and clears the running tick. A rest gives none.
// The first byte of an item passes the input register, the tick multiply register
// and the output buffer before it is offered.
// Throughput: one byte per cycle while out_ready holds, set by the single-byte
// output port; rests pass at one per cycle unless held behind a stalled item.
// The input side keeps accepting items while a finished burst drains, up to two
// items held in the pipeline registers.
// A stalled receiver holds the current byte and the pipeline fills, after which
// in_ready falls. Reset empties the pipeline, clears the running tick and loads
// the register defaults: key of C major, 480 ticks per quarter, voice 0.
`include "midi_note_track_encoder_core_defines.svh"

module midi_note_track_encoder_core #(
	parameter int TICK_BITS = mnte_pkg::TICK_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [15:0] start_beat,
	input  logic [4:0]  scale_degree,
	input  logic [3:0]  duration_code,
	input  logic        is_rest,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last
);

	localparam int DB = mnte_pkg::DUR_BITS;
	localparam int VB = mnte_pkg::VEC_BITS;
	localparam logic [31:0] TICK_TOP = 32'((64'd1 << TICK_BITS) - 64'd1);

	logic [3:0]                    key_root_q;
	logic                          key_minor_q;
	logic [mnte_pkg::TPQ_BITS-1:0] tpq_q;
	logic [1:0]                    voice_q;
	logic [TICK_BITS-1:0]          rt_q;

	logic        valid_s1;
	logic        op_s1;
	logic [15:0] start_s1;
	logic [4:0]  deg_s1;
	logic [3:0]  code_s1;
	logic        rest_s1;

	logic                 valid_s2;
	logic                 op_s2;
	logic                 rest_s2;
	logic [TICK_BITS-1:0] ev_s2;
	logic [TICK_BITS-1:0] dur_s2;
	logic [6:0]           note_s2;

	logic ready_s1;
	logic ready_s2;
	logic s2_go;
	logic load_valid;
	logic load_ready;

	logic [30:0]          prod;
	logic [22:0]          ev_full;
	logic [TICK_BITS-1:0] ev_sat;
	logic [DB-1:0]        dur_full;
	logic [TICK_BITS-1:0] dur_sat;

	logic [TICK_BITS-1:0] delta;
	logic [TICK_BITS:0]   end_sum;
	logic [TICK_BITS-1:0] end_tick;
	mnte_pkg::vlq_t       dvlq;
	mnte_pkg::vlq_t       uvlq;
	logic [VB-1:0]        vec;
	logic [7:0]           on_stat;
	logic [7:0]           off_stat;
	mnte_pkg::burst_t     burst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_root_q  <= '0;
			key_minor_q <= 1'b0;
			tpq_q       <= mnte_pkg::TPQ_RESET;
			voice_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mnte_pkg::CFG_KEY_ROOT:  key_root_q  <= cfg_data[3:0];
				mnte_pkg::CFG_KEY_MINOR: key_minor_q <= cfg_data[0];
				mnte_pkg::CFG_TPQ:       tpq_q       <= cfg_data;
				mnte_pkg::CFG_VOICE:     voice_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign load_valid = valid_s2 && (op_s2 || !rest_s2);
	assign s2_go      = valid_s2 && (load_ready || (!op_s2 && rest_s2));
	assign ready_s2   = !valid_s2 || s2_go;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign in_ready   = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			op_s1    <= op;
			start_s1 <= start_beat;
			deg_s1   <= scale_degree;
			code_s1  <= duration_code;
			rest_s1  <= is_rest;
		end
	end

	// Event tick is the 8.8 start beat times the resolution, fraction dropped.
	always_comb begin
		prod     = 31'(start_s1) * 31'(tpq_q);
		ev_full  = prod[30:8];
		ev_sat   = (32'(ev_full) > TICK_TOP) ? TICK_TOP[TICK_BITS-1:0] : TICK_BITS'(ev_full);
		dur_full = mnte_pkg::duration_ticks(code_s1, tpq_q);
		dur_sat  = (32'(dur_full) > TICK_TOP) ? TICK_TOP[TICK_BITS-1:0] : TICK_BITS'(dur_full);
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			op_s2   <= op_s1;
			rest_s2 <= rest_s1;
			ev_s2   <= ev_sat;
			dur_s2  <= dur_sat;
			note_s2 <= mnte_pkg::note_number(key_root_q, key_minor_q, voice_q, deg_s1);
		end
	end

	// An event that starts before the running tick gets a single byte holding
	// the low seven bits of the wrapped difference.
	always_comb begin
		delta    = ev_s2 - rt_q;
		end_sum  = {1'b0, ev_s2} + {1'b0, dur_s2};
		end_tick = end_sum[TICK_BITS] ? TICK_TOP[TICK_BITS-1:0] : end_sum[TICK_BITS-1:0];
		if (ev_s2 >= rt_q) begin
			dvlq = mnte_pkg::vlq_encode(mnte_pkg::VLQ_BITS'(delta));
		end else begin
			dvlq.bytes = {24'd0, 1'b0, delta[6:0]};
			dvlq.count = 3'd1;
		end
		uvlq     = mnte_pkg::vlq_encode(mnte_pkg::VLQ_BITS'(dur_s2));
		on_stat  = {mnte_pkg::NOTE_ON, 2'b00, voice_q};
		off_stat = {mnte_pkg::NOTE_OFF, 2'b00, voice_q};
		vec = VB'({8'h00, 1'b0, note_s2, off_stat});
		vec = (vec << {uvlq.count, 3'b000}) | VB'(uvlq.bytes);
		vec = (vec << 24) | VB'({mnte_pkg::VELOCITY, 1'b0, note_s2, on_stat});
		vec = (vec << {dvlq.count, 3'b000}) | VB'(dvlq.bytes);
		if (op_s2) begin
			burst.bytes = VB'({8'h00, mnte_pkg::META_EOT, mnte_pkg::META_EVENT, 8'h00});
			burst.count = mnte_pkg::CNT_BITS'(mnte_pkg::MIN_BURST);
		end else begin
			burst.bytes = vec;
			burst.count = mnte_pkg::CNT_BITS'(dvlq.count) + mnte_pkg::CNT_BITS'(uvlq.count)
				+ mnte_pkg::CNT_BITS'(6);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_q <= '0;
		end else if (s2_go) begin
			if (op_s2) begin
				rt_q <= '0;
			end else if (!rest_s2) begin
				rt_q <= end_tick;
			end
		end
	end

	mnte_byte_out u_byte_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.load_ready (load_ready),
		.burst      (burst),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last       (last)
	);

	`MNTE_ASSERT(a_rest_keeps_tick, (s2_go && !op_s2 && rest_s2) |=> $stable(rt_q), "rest moved the running tick")
	`MNTE_ASSERT(a_end_clears_tick, (s2_go && op_s2) |=> (rt_q == '0), "end item left the running tick set")
	`MNTE_ASSERT(a_s1_holds, (valid_s1 && !ready_s2) |=> (valid_s1 && $stable(start_s1)), "stalled input stage lost its item")

endmodule

>>> hdl/mnte_byte_out.sv
`include "midi_note_track_encoder_core_defines.svh"

module mnte_byte_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_valid,
	output logic                load_ready,
	input  mnte_pkg::burst_t    burst,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                last
);

	localparam int CNTW = mnte_pkg::CNT_BITS;
	localparam logic [CNTW-1:0] MAX_CNT = CNTW'(mnte_pkg::MAX_BYTES);
	localparam logic [CNTW-1:0] MIN_CNT = CNTW'(mnte_pkg::MIN_BURST);

	logic [mnte_pkg::VEC_BITS-1:0] shreg_q;
	logic [CNTW-1:0]               cnt_q;

	assign out_valid  = (cnt_q != '0);
	assign out_byte   = shreg_q[7:0];
	assign last       = (cnt_q == CNTW'(1));
	assign load_ready = (cnt_q == '0) || (last && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load_valid && load_ready) begin
			cnt_q <= burst.count;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			shreg_q <= burst.bytes;
		end else if (out_valid && out_ready) begin
			shreg_q <= shreg_q >> 8;
		end
	end

	`MNTE_ASSERT_NEVER(a_count_range, cnt_q > MAX_CNT, "byte count beyond buffer size")
	`MNTE_ASSERT(a_burst_continues, (out_valid && out_ready && !last) |=> out_valid, "burst cut short")
	`MNTE_ASSERT(a_load_size, (load_valid && load_ready) |-> (burst.count >= MIN_CNT), "burst too short")

endmodule
